// File: rtl/sorted_key_value_table_assert.svh
// assertion macros shared by the sorted key/value table
`ifndef SORTED_KEY_VALUE_TABLE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SKVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_key_value_table: check failed");

// next-cycle implication, checked outside reset
`define SKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_key_value_table: check failed");

`endif

// File: rtl/skvt_pkg.sv
// shared types and constants of the sorted key/value table
package skvt_pkg;

    localparam int KEY_PORT_W    = 32;
    localparam int VALUE_PORT_W  = 32;
    localparam int STATUS_W      = 3;
    localparam int GROUP_SIZE    = 16;

    localparam logic KIND_DEFINE = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERWRITTEN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;

    // control broadcast to every cell
    typedef struct packed {
        logic cmp;   // capture compare flags against the broadcast key
        logic ins;   // insert: cells at or above the slot shift up by one
        logic ovr;   // overwrite the value of the matching cell
    } t_cell_ctrl;

endpackage

// File: rtl/skvt_cell.sv
// one table cell: holds a key/value pair and shifts from its lower neighbour
module skvt_cell #(
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  skvt_pkg::t_cell_ctrl  i_ctrl,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [VAL_W-1:0]      i_value,
    input  logic                  i_prev_lt,
    input  logic                  i_prev_valid,
    input  logic [KEY_W-1:0]      i_prev_key,
    input  logic [VAL_W-1:0]      i_prev_value,
    output logic                  o_lt,
    output logic                  o_valid,
    output logic [KEY_W-1:0]      o_key,
    output logic [VAL_W-1:0]      o_value,
    output logic                  o_match,
    output logic [VAL_W-1:0]      o_match_value
);

    logic             r_valid;
    logic             r_lt;
    logic             r_eq;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic             w_lt;
    logic             w_eq;
    logic             w_shift;

    assign w_lt    = r_valid && (r_key < i_key);
    assign w_eq    = r_valid && (r_key == i_key);
    // cells below the slot keep their entry, the rest move up
    assign w_shift = i_ctrl.ins && !r_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctrl.cmp) begin
                r_lt <= w_lt;
                r_eq <= w_eq;
            end
            if (w_shift) begin
                r_valid <= i_prev_lt ? 1'b1 : i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            // first cell not below the new key takes the new pair
            r_key   <= i_prev_lt ? i_key : i_prev_key;
            r_value <= i_prev_lt ? i_value : i_prev_value;
        end else if (i_ctrl.ovr && r_eq) begin
            r_value <= i_value;
        end
    end

    assign o_lt          = r_lt;
    assign o_valid       = r_valid;
    assign o_key         = r_key;
    assign o_value       = r_value;
    assign o_match       = w_eq;
    assign o_match_value = w_eq ? r_value : '0;

endmodule

// File: rtl/sorted_key_value_table.sv
// a new request is taken only while idle or as the last one leaves S_UPD
// compare in all cells in S_CMP; S_UPD shifts or overwrites on a define and waits for a free output
// the match and found value are gathered through a registered OR tree of 16-cell groups
// reset clears the entry count, the cell valid flags and both handshakes
// keys and values in the cells hold no reset value and are only read once written
`include "sorted_key_value_table_assert.svh"

module sorted_key_value_table #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic [skvt_pkg::KEY_PORT_W-1:0]     i_key,
    input  logic [skvt_pkg::VALUE_PORT_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [skvt_pkg::STATUS_W-1:0]       o_status,
    output logic [skvt_pkg::VALUE_PORT_W-1:0]   o_found_value
);

    localparam int KW = (KEY_BITS < skvt_pkg::KEY_PORT_W) ? KEY_BITS : skvt_pkg::KEY_PORT_W;
    localparam int VW = (VALUE_BITS < skvt_pkg::VALUE_PORT_W) ?
                        VALUE_BITS : skvt_pkg::VALUE_PORT_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int GS = skvt_pkg::GROUP_SIZE;
    localparam int NG = (CAPACITY + GS - 1) / GS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]                         r_state;
    logic [1:0]                         n_state;
    logic                               r_kind;
    logic [KW-1:0]                      r_key;
    logic [VW-1:0]                      r_value;
    logic [CW-1:0]                      r_count;
    logic                               r_out_valid;
    logic [skvt_pkg::STATUS_W-1:0]      r_status;
    logic [VW-1:0]                      r_found;
    logic [NG-1:0]                      r_grp_hit;
    logic [VW-1:0]                      r_grp_val [NG];

    logic                               w_upd_go;
    logic                               w_in_fire;
    logic                               w_full;
    logic                               w_hit;
    logic [VW-1:0]                      w_found;
    logic [skvt_pkg::STATUS_W-1:0]      w_status;
    skvt_pkg::t_cell_ctrl               w_ctrl;
    logic [NG-1:0]                      w_grp_hit;
    logic [VW-1:0]                      w_grp_val [NG];

    logic [CAPACITY-1:0]                w_lt;
    logic [CAPACITY-1:0]                w_cvalid;
    logic [CAPACITY-1:0]                w_match;
    logic [KW-1:0]                      w_ckey   [CAPACITY];
    logic [VW-1:0]                      w_cval   [CAPACITY];
    logic [VW-1:0]                      w_mval   [CAPACITY];

    // handshake and sequencing
    assign w_upd_go   = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || w_upd_go;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(CAPACITY));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_upd_go) n_state = w_in_fire ? S_CMP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_kind  <= i_kind;
            r_key   <= i_key[KW-1:0];
            r_value <= i_value[VW-1:0];
        end
    end

    // cell row
    always_comb begin
        w_ctrl.cmp = (r_state == S_CMP);
        w_ctrl.ins = w_upd_go && (r_kind == skvt_pkg::KIND_DEFINE) && !w_hit && !w_full;
        w_ctrl.ovr = w_upd_go && (r_kind == skvt_pkg::KIND_DEFINE) && w_hit;
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            skvt_cell #(.KEY_W(KW), .VAL_W(VW)) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_key         (r_key),
                .i_value       (r_value),
                .i_prev_lt     (1'b1),
                .i_prev_valid  (1'b0),
                .i_prev_key    ({KW{1'b0}}),
                .i_prev_value  ({VW{1'b0}}),
                .o_lt          (w_lt[gi]),
                .o_valid       (w_cvalid[gi]),
                .o_key         (w_ckey[gi]),
                .o_value       (w_cval[gi]),
                .o_match       (w_match[gi]),
                .o_match_value (w_mval[gi])
            );
        end else begin : g_rest
            skvt_cell #(.KEY_W(KW), .VAL_W(VW)) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_key         (r_key),
                .i_value       (r_value),
                .i_prev_lt     (w_lt[gi-1]),
                .i_prev_valid  (w_cvalid[gi-1]),
                .i_prev_key    (w_ckey[gi-1]),
                .i_prev_value  (w_cval[gi-1]),
                .o_lt          (w_lt[gi]),
                .o_valid       (w_cvalid[gi]),
                .o_key         (w_ckey[gi]),
                .o_value       (w_cval[gi]),
                .o_match       (w_match[gi]),
                .o_match_value (w_mval[gi])
            );
        end
    end

    // first level of the match tree: one OR per group of cells
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            w_grp_hit[g] = 1'b0;
            w_grp_val[g] = '0;
            for (int j = 0; j < GS; j++) begin
                if (g * GS + j < CAPACITY) begin
                    w_grp_hit[g] = w_grp_hit[g] | w_match[g * GS + j];
                    w_grp_val[g] = w_grp_val[g] | w_mval[g * GS + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_hit <= '0;
        end else if (r_state == S_CMP) begin
            r_grp_hit <= w_grp_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP) begin
            for (int g = 0; g < NG; g++) begin
                r_grp_val[g] <= w_grp_val[g];
            end
        end
    end

    // second level of the tree and the result
    always_comb begin
        w_found = '0;
        for (int g = 0; g < NG; g++) begin
            w_found = w_found | r_grp_val[g];
        end
    end

    assign w_hit = |r_grp_hit;

    always_comb begin
        if (r_kind == skvt_pkg::KIND_DEFINE) begin
            if (w_hit) begin
                w_status = skvt_pkg::ST_OVERWRITTEN;
            end else if (w_full) begin
                w_status = skvt_pkg::ST_FULL;
            end else begin
                w_status = skvt_pkg::ST_INSERTED;
            end
        end else begin
            w_status = w_hit ? skvt_pkg::ST_FOUND : skvt_pkg::ST_NOT_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctrl.ins) begin
                r_count <= r_count + CW'(1);
            end
            if (w_upd_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_go) begin
            r_status <= w_status;
            r_found  <= (r_kind == skvt_pkg::KIND_LOOKUP && w_hit) ? w_found : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = skvt_pkg::VALUE_PORT_W'(r_found);

    // checks
    `SKVT_ASSERT_NOW(a_count_matches_cells, i_clk, i_rst_n, 1'b1,
        $countones(w_cvalid) == int'(r_count))
    `SKVT_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1,
        int'(r_count) <= CAPACITY)
    `SKVT_ASSERT_NEXT(a_compare_then_update, i_clk, i_rst_n, r_state == S_CMP,
        r_state == S_UPD)
    `SKVT_ASSERT_NOW(a_full_only_when_full, i_clk, i_rst_n,
        r_out_valid && r_status == skvt_pkg::ST_FULL, w_full)

endmodule

// File: tb/testbench.sv
// self-checking testbench for the sorted key/value table
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_DEPTH    = 256;
    localparam int ITEM_TARGET    = 1750;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct {
        logic                              kind;
        logic [skvt_pkg::KEY_PORT_W-1:0]   key;
        logic [skvt_pkg::VALUE_PORT_W-1:0] value;
    } t_table_request;

    typedef struct {
        logic [skvt_pkg::STATUS_W-1:0]     status;
        logic [skvt_pkg::VALUE_PORT_W-1:0] found_value;
    } t_table_answer;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic                              i_kind = skvt_pkg::KIND_DEFINE;
    logic [skvt_pkg::KEY_PORT_W-1:0]   i_key = '0;
    logic [skvt_pkg::VALUE_PORT_W-1:0] i_value = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic [skvt_pkg::STATUS_W-1:0]     o_status;
    logic [skvt_pkg::VALUE_PORT_W-1:0] o_found_value;

    sorted_key_value_table #(
        .CAPACITY   (TABLE_DEPTH),
        .KEY_BITS   (skvt_pkg::KEY_PORT_W),
        .VALUE_BITS (skvt_pkg::VALUE_PORT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_value (o_found_value)
    );

    always #6 i_clk = ~i_clk;

    // shadow copy of the table, kept in ascending key order
    logic [skvt_pkg::KEY_PORT_W-1:0]   shadow_keys [TABLE_DEPTH];
    logic [skvt_pkg::VALUE_PORT_W-1:0] shadow_values [TABLE_DEPTH];
    int unsigned                       shadow_count = 0;

    t_table_request                    pending_requests[$];
    t_table_answer                     expected_answers[$];
    logic [skvt_pkg::KEY_PORT_W-1:0]   issued_keys[$];

    int unsigned requests_queued = 0;
    int unsigned requests_sent = 0;
    int unsigned answers_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned status_tally [5] = '{default: 0};

    function automatic void predict_answer(logic kind, logic [skvt_pkg::KEY_PORT_W-1:0] key,
                                           logic [skvt_pkg::VALUE_PORT_W-1:0] value);
        int unsigned   slot;
        int unsigned   idx;
        bit            hit;
        t_table_answer ans;
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] < key)
            slot++;
        hit = (slot < shadow_count) && (shadow_keys[slot] == key);
        ans.found_value = '0;
        if (kind == skvt_pkg::KIND_DEFINE) begin
            if (hit) begin
                shadow_values[slot] = value;
                ans.status = skvt_pkg::ST_OVERWRITTEN;
            end else if (shadow_count >= TABLE_DEPTH) begin
                ans.status = skvt_pkg::ST_FULL;
            end else begin
                // open the slot by moving the larger keys up
                for (idx = shadow_count; idx > slot; idx--) begin
                    shadow_keys[idx]   = shadow_keys[idx-1];
                    shadow_values[idx] = shadow_values[idx-1];
                end
                shadow_keys[slot]   = key;
                shadow_values[slot] = value;
                shadow_count++;
                ans.status = skvt_pkg::ST_INSERTED;
            end
        end else if (hit) begin
            ans.found_value = shadow_values[slot];
            ans.status = skvt_pkg::ST_FOUND;
        end else begin
            ans.status = skvt_pkg::ST_NOT_FOUND;
        end
        status_tally[ans.status]++;
        expected_answers.push_back(ans);
    endfunction

    function automatic int unsigned draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // sender
    int unsigned    send_wait = 0;
    bit             sender_calm = 1'b0;
    t_table_request next_request;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_answer(i_kind, i_key, i_value);
                requests_sent++;
                if ($urandom_range(0, 49) == 0)
                    sender_calm = ~sender_calm;
                send_wait = draw_wait(sender_calm);
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    next_request = pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                    i_kind     <= next_request.kind;
                    i_key      <= next_request.key;
                    i_value    <= next_request.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    int unsigned   recv_wait = 0;
    bit            receiver_calm = 1'b0;
    t_table_answer oldest_answer;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                answers_checked++;
                if (expected_answers.size() == 0) begin
                    $error("unexpected result beat: status %0d, found_value 0x%08h",
                           o_status, o_found_value);
                    mismatch_count++;
                end else begin
                    oldest_answer = expected_answers.pop_front();
                    if (o_status !== oldest_answer.status) begin
                        $error("status: expected %0d, got %0d",
                               oldest_answer.status, o_status);
                        mismatch_count++;
                    end
                    if (o_found_value !== oldest_answer.found_value) begin
                        $error("found_value: expected 0x%08h, got 0x%08h",
                               oldest_answer.found_value, o_found_value);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 49) == 0)
                    receiver_calm = ~receiver_calm;
                recv_wait = draw_wait(receiver_calm);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any beat while work is outstanding
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else if (i_in_valid || pending_requests.size() != 0 || expected_answers.size() != 0)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_answers.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_request(logic kind, logic [skvt_pkg::KEY_PORT_W-1:0] key,
                               logic [skvt_pkg::VALUE_PORT_W-1:0] value);
        t_table_request req;
        req.kind  = kind;
        req.key   = key;
        req.value = value;
        pending_requests.push_back(req);
        if (kind == skvt_pkg::KIND_DEFINE)
            issued_keys.push_back(key);
        requests_queued++;
    endtask

    // known keys mostly give hits, fresh ones lean on the edges of the key range
    function automatic logic [skvt_pkg::KEY_PORT_W-1:0] pick_key(bit fresh);
        logic [skvt_pkg::KEY_PORT_W-1:0] base;
        if (!fresh && issued_keys.size() != 0)
            return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 15);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2: begin
                if (issued_keys.size() == 0)
                    return $urandom();
                base = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
                return $urandom_range(0, 1) ? base + 1 : base - 1;
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic add_random_request(int unsigned lookup_pct, int unsigned fresh_pct);
        logic kind;
        kind = ($urandom_range(0, 99) < lookup_pct) ? skvt_pkg::KIND_LOOKUP
                                                     : skvt_pkg::KIND_DEFINE;
        add_request(kind, pick_key($urandom_range(0, 99) < fresh_pct), $urandom());
    endtask

    // wait until every queued request is sent and every outstanding result is back
    task automatic wait_for_drain();
        do
            @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || send_wait != 0
               || expected_answers.size() != 0);
    endtask

    initial begin
        // empty table, then inserts at front, back and middle, lookups and overwrites
        add_request(skvt_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        add_request(skvt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(skvt_pkg::KIND_DEFINE, 32'h0000_0005, 32'hFFFF_FFFF);
        add_request(skvt_pkg::KIND_DEFINE, 32'h0000_0000, 32'h0000_0000);
        add_request(skvt_pkg::KIND_DEFINE, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        add_request(skvt_pkg::KIND_DEFINE, 32'h0000_0003, 32'h0000_0001);
        add_request(skvt_pkg::KIND_DEFINE, 32'h8000_0000, 32'h5555_5555);
        add_request(skvt_pkg::KIND_DEFINE, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        add_request(skvt_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h1234_5678);
        add_request(skvt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        add_request(skvt_pkg::KIND_LOOKUP, 32'h0000_0005, 32'h0000_0000);
        add_request(skvt_pkg::KIND_LOOKUP, 32'h0000_0003, 32'hDEAD_BEEF);
        add_request(skvt_pkg::KIND_LOOKUP, 32'h0000_0004, 32'h0000_0000);
        add_request(skvt_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        add_request(skvt_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        add_request(skvt_pkg::KIND_LOOKUP, 32'h8000_0001, 32'h0000_0000);
        add_request(skvt_pkg::KIND_DEFINE, 32'h0000_0005, 32'h1234_5678);
        add_request(skvt_pkg::KIND_LOOKUP, 32'h0000_0005, 32'h0000_0000);
        add_request(skvt_pkg::KIND_DEFINE, 32'h0000_0000, 32'hFFFF_FFFF);
        add_request(skvt_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        add_request(skvt_pkg::KIND_DEFINE, 32'hFFFF_FFFF, 32'h0000_0000);
        add_request(skvt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // growing table with a mix of hits and misses
        repeat (700) add_random_request(40, 40);
        wait_for_drain();

        // top the table up until it is full
        while (shadow_count < TABLE_DEPTH) begin
            repeat (TABLE_DEPTH - shadow_count) add_random_request(20, 100);
            wait_for_drain();
        end

        // full table: overwrites, dropped inserts and lookups
        while (requests_queued < ITEM_TARGET)
            add_random_request(45, 35);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d items sent, %0d results checked, %0d mismatches, table holds %0d",
                 requests_sent, answers_checked, mismatch_count, shadow_count);
        $display("inserted %0d, overwritten %0d, dropped when full %0d, hit %0d, missed %0d",
                 status_tally[skvt_pkg::ST_INSERTED], status_tally[skvt_pkg::ST_OVERWRITTEN],
                 status_tally[skvt_pkg::ST_FULL], status_tally[skvt_pkg::ST_FOUND],
                 status_tally[skvt_pkg::ST_NOT_FOUND]);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/sorted_key_value_table.sv
tb/testbench.sv
